[rtl/core/audio_block_level_meter_defines.svh]
// Assertion macros used by the level meter datapath.
`ifndef AUDIO_BLOCK_LEVEL_METER_DEFINES_SVH
`define AUDIO_BLOCK_LEVEL_METER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, disabled during reset.
`define ABLM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, disabled during reset.
`define ABLM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ablm_pkg.sv]
// Types, constants and helper functions of the audio block level meter.
package ablm_pkg;

    localparam int MAX_BLOCK = 128;
    localparam int BAR_LEN   = 40;

    localparam int WORD_W   = 32;
    localparam int SAMPLE_W = 24;
    localparam int SUM_W    = 31;
    localparam int CNT_W    = $clog2(MAX_BLOCK + 1);
    localparam int PCT_W    = 7;
    localparam int FILL_W   = 6;
    localparam int BAR_W    = 8;
    localparam int PROD_W   = SAMPLE_W + PCT_W;
    localparam int FILLP_W  = PCT_W + BAR_W;
    localparam int STEP_W   = $clog2(SUM_W);
    localparam int RECIP_W  = 13;
    localparam int RECIP_SH = 19;
    localparam int FS_W     = 23;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 24'h7FFFFF;
    localparam logic [PCT_W-1:0]    PCT_SCALE  = 7'd100;
    localparam logic [BAR_W-1:0]    BAR_LEN_C  = BAR_W'(BAR_LEN);
    localparam logic [CNT_W-1:0]    MAX_CNT    = CNT_W'(MAX_BLOCK);
    localparam logic [RECIP_W-1:0]  RECIP_100  = 13'd5243;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic acc_en;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_sts;

    // Peak times 100 divided by 2^23 - 1: the estimate p >> 23 is off by at most one.
    function automatic logic [PCT_W-1:0] pct_of(input logic [PROD_W-1:0] p);
        logic [PROD_W-FS_W-1:0] q0;
        logic [SAMPLE_W-1:0]    r;
        logic [PROD_W-FS_W-1:0] q;
        q0 = p[PROD_W-1:FS_W];
        r  = {1'b0, p[FS_W-1:0]} + SAMPLE_W'(q0);
        q  = q0 + (PROD_W-FS_W)'(r >= FULL_SCALE);
        return q[PCT_W-1:0];
    endfunction

    // Division by 100 through a reciprocal, exact for the range used, then clamped.
    function automatic logic [FILL_W-1:0] fill_of(input logic [FILLP_W-1:0] x);
        logic [FILLP_W+RECIP_W-1:0] m;
        logic [FILLP_W+RECIP_W-RECIP_SH-1:0] q;
        m = FILLP_W'(x) * (FILLP_W+RECIP_W)'(RECIP_100);
        q = m[FILLP_W+RECIP_W-1:RECIP_SH];
        if (q > (FILLP_W+RECIP_W-RECIP_SH)'(BAR_LEN_C)) begin
            q = (FILLP_W+RECIP_W-RECIP_SH)'(BAR_LEN_C);
        end
        return q[FILL_W-1:0];
    endfunction

endpackage

[rtl/core/ablm_div.sv]
// Restoring serial divider, one quotient bit per step.
module ablm_div (
    input  logic                        i_clk,
    input  logic                        i_start,
    input  logic                        i_step,
    input  logic [ablm_pkg::SUM_W-1:0]  i_dividend,
    input  logic [ablm_pkg::CNT_W-1:0]  i_divisor,
    output logic [ablm_pkg::SUM_W-1:0]  o_quotient,
    output logic                        o_last
);
    import ablm_pkg::*;

    logic [SUM_W-1:0]  r_num;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_cnt;
    logic [CNT_W:0]    n_trial;
    logic              n_ge;

    always_comb begin
        n_trial = {r_rem, r_num[SUM_W-1]};
        n_ge    = n_trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= STEP_W'(SUM_W - 1);
        end else if (i_step) begin
            r_num <= {r_num[SUM_W-2:0], n_ge};
            if (n_ge) begin
                r_rem <= CNT_W'(n_trial - {1'b0, r_div});
            end else begin
                r_rem <= n_trial[CNT_W-1:0];
            end
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    assign o_quotient = r_num;
    assign o_last     = (r_cnt == '0);

endmodule

[rtl/core/ablm_ctrl.sv]
// Control state machine of the audio block level meter.
module ablm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_block_end,
    output logic           o_ready,
    output ablm_pkg::t_cmd o_cmd,
    input  ablm_pkg::t_sts i_sts
);
    import ablm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.acc_en = i_valid;
                if (i_valid && i_block_end) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/ablm_dp.sv]
// Datapath: accumulators, serial mean divider, percent and bar scaling, result register.
`include "audio_block_level_meter_defines.svh"

module ablm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ablm_pkg::t_cmd                i_cmd,
    output ablm_pkg::t_sts                o_sts,
    input  logic [ablm_pkg::WORD_W-1:0]   i_sample_word,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ablm_pkg::SAMPLE_W-1:0] o_peak_level,
    output logic [ablm_pkg::SAMPLE_W-1:0] o_mean_level,
    output logic [ablm_pkg::PCT_W-1:0]    o_percent_full,
    output logic [ablm_pkg::FILL_W-1:0]   o_bar_fill
);
    import ablm_pkg::*;

    logic [SAMPLE_W-1:0] r_peak;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic [PROD_W-1:0]   r_prod;
    logic [PCT_W-1:0]    r_pct;
    logic [FILLP_W-1:0]  r_fill_prod;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_peak;
    logic [SAMPLE_W-1:0] r_out_mean;
    logic [PCT_W-1:0]    r_out_pct;
    logic [FILL_W-1:0]   r_out_fill;

    logic [SAMPLE_W-1:0] n_sample;
    logic [SAMPLE_W-1:0] n_mag;
    logic                n_keep;
    logic [CNT_W-1:0]    n_divisor;
    logic [SUM_W-1:0]    n_quotient;
    logic                n_div_last;

    always_comb begin
        n_sample  = i_sample_word[WORD_W-1:WORD_W-SAMPLE_W];
        n_mag     = n_sample[SAMPLE_W-1] ? (~n_sample + SAMPLE_W'(1)) : n_sample;
        n_keep    = i_cmd.acc_en && (r_count < MAX_CNT);
        n_divisor = (r_count == '0) ? CNT_W'(1) : r_count;
    end

    ablm_div u_div (
        .i_clk      (i_clk),
        .i_start    (i_cmd.div_start),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_sum),
        .i_divisor  (n_divisor),
        .o_quotient (n_quotient),
        .o_last     (n_div_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.out_load) begin
            r_peak  <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else if (n_keep) begin
            if (n_mag > r_peak) begin
                r_peak <= n_mag;
            end
            r_sum   <= r_sum + SUM_W'(n_mag);
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_prod <= PROD_W'(r_peak) * PROD_W'(PCT_SCALE);
        end
        if (i_cmd.div_step) begin
            r_pct       <= pct_of(r_prod);
            r_fill_prod <= FILLP_W'(r_pct) * FILLP_W'(BAR_LEN_C);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_peak <= r_peak;
            r_out_mean <= n_quotient[SAMPLE_W-1:0];
            r_out_pct  <= r_pct;
            r_out_fill <= fill_of(r_fill_prod);
        end
    end

    assign o_sts.div_last = n_div_last;
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid        = r_out_valid;
    assign o_peak_level   = r_out_peak;
    assign o_mean_level   = r_out_mean;
    assign o_percent_full = r_out_pct;
    assign o_bar_fill     = r_out_fill;

    `ABLM_ASSERT_NOW(a_count_bound, 1'b1, r_count <= MAX_CNT, "word count above block limit")
    `ABLM_ASSERT_NOW(a_load_free, i_cmd.out_load, !r_out_valid || i_ready, "result overwritten")
    `ABLM_ASSERT_NEXT(a_clear, i_cmd.out_load, r_count == '0 && r_peak == '0 && r_sum == '0,
        "accumulators not cleared after result")

endmodule

[rtl/core/audio_block_level_meter.sv]
// Block level meter: per-block peak, mean, percent of full scale and bar fill of audio words.
// Each beat carries one MSB-justified 32-bit word; the upper 24 bits are taken as a signed
// sample and its magnitude goes into a running peak, sum and word count (words beyond 128
// in one block are ignored, but a flagged one still closes the block). Words without the
// block-end flag are taken one per clock. After a flagged word no new word is taken until
// the block is through: the word is accepted, the divider is prepared, the bit-serial
// mean divider steps through its quotient bits, and the result register is loaded, later if
// that register still holds an untaken result. The result holds in its register until taken,
// and the accumulators start again from zero.
module audio_block_level_meter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ablm_pkg::WORD_W-1:0]   i_sample_word,
    input  logic                          i_block_end,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ablm_pkg::SAMPLE_W-1:0] o_peak_level,
    output logic [ablm_pkg::SAMPLE_W-1:0] o_mean_level,
    output logic [ablm_pkg::PCT_W-1:0]    o_percent_full,
    output logic [ablm_pkg::FILL_W-1:0]   o_bar_fill
);
    import ablm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ablm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_block_end (i_block_end),
        .o_ready     (o_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    ablm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_sample_word  (i_sample_word),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_peak_level   (o_peak_level),
        .o_mean_level   (o_mean_level),
        .o_percent_full (o_percent_full),
        .o_bar_fill     (o_bar_fill)
    );

endmodule

[tb/tb.sv]
// Self-checking testbench of the audio block level meter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_ITEMS  = 1000;
    localparam int DRAIN_WAIT  = 80;
    localparam int NUM_DIR     = 20;

    typedef struct packed {
        logic [ablm_pkg::SAMPLE_W-1:0] peak;
        logic [ablm_pkg::SAMPLE_W-1:0] mean;
        logic [ablm_pkg::PCT_W-1:0]    pct;
        logic [ablm_pkg::FILL_W-1:0]   fill;
    } t_level;

    typedef struct packed {
        logic [ablm_pkg::WORD_W-1:0] word;
        logic                        last;
        int                          reps;
        logic                        typed;
        t_level                      want;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [ablm_pkg::WORD_W-1:0]   i_sample_word = '0;
    logic                          i_block_end = 1'b0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [ablm_pkg::SAMPLE_W-1:0] o_peak_level;
    logic [ablm_pkg::SAMPLE_W-1:0] o_mean_level;
    logic [ablm_pkg::PCT_W-1:0]    o_percent_full;
    logic [ablm_pkg::FILL_W-1:0]   o_bar_fill;

    logic [ablm_pkg::SAMPLE_W-1:0] run_peak = '0;
    logic [ablm_pkg::SUM_W-1:0]    run_sum = '0;
    logic [7:0]                    run_words = '0;

    t_level levels_due[$];
    int     fail_cnt = 0;
    int     beats_sent = 0;
    int     blocks_sent = 0;
    int     long_blocks = 0;
    int     levels_checked = 0;
    int     stall_cnt = 0;
    logic   calm = 1'b0;
    logic   hold_req = 1'b0;
    logic   hold_ack = 1'b0;

    t_stim_row dir_tab [NUM_DIR] = '{
        '{32'h0000_0000, 1'b1, 1,   1'b1, '{24'h000000, 24'h000000, 7'd0,   6'd0}},
        '{32'h8000_0000, 1'b1, 1,   1'b1, '{24'h800000, 24'h800000, 7'd100, 6'd40}},
        '{32'h7FFF_FF00, 1'b1, 1,   1'b1, '{24'h7FFFFF, 24'h7FFFFF, 7'd100, 6'd40}},
        '{32'h7FFF_FFFF, 1'b1, 1,   1'b1, '{24'h7FFFFF, 24'h7FFFFF, 7'd100, 6'd40}},
        '{32'hFFFF_FFFF, 1'b1, 1,   1'b1, '{24'h000001, 24'h000001, 7'd0,   6'd0}},
        '{32'h0000_00FF, 1'b1, 1,   1'b1, '{24'h000000, 24'h000000, 7'd0,   6'd0}},
        '{32'h0000_0100, 1'b1, 1,   1'b1, '{24'h000001, 24'h000001, 7'd0,   6'd0}},
        '{32'h4000_0000, 1'b0, 1,   1'b0, '0},
        '{32'hC000_0000, 1'b0, 1,   1'b0, '0},
        '{32'h0000_0000, 1'b1, 1,   1'b0, '0},
        '{32'h1234_5600, 1'b0, 1,   1'b0, '0},
        '{32'hFFFF_FF00, 1'b0, 1,   1'b0, '0},
        '{32'h55AA_5500, 1'b0, 1,   1'b0, '0},
        '{32'h8000_0000, 1'b1, 1,   1'b0, '0},
        '{32'h3FFF_FF00, 1'b1, 1,   1'b0, '0},
        '{32'hC000_0100, 1'b1, 1,   1'b0, '0},
        '{32'h0000_0100, 1'b0, 128, 1'b0, '0},
        '{32'h8000_0000, 1'b1, 2,   1'b1, '{24'h000001, 24'h000001, 7'd0,   6'd0}},
        '{32'h8000_0000, 1'b0, 127, 1'b0, '0},
        '{32'h7FFF_FF00, 1'b1, 1,   1'b1, '{24'h800000, 24'h7FFFFF, 7'd100, 6'd40}}
    };

    audio_block_level_meter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_word  (i_sample_word),
        .i_block_end    (i_block_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_peak_level   (o_peak_level),
        .o_mean_level   (o_mean_level),
        .o_percent_full (o_percent_full),
        .o_bar_fill     (o_bar_fill)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic meter_step(input logic [ablm_pkg::WORD_W-1:0] w,
                                        input logic last, output t_level lvl);
        logic [ablm_pkg::SAMPLE_W-1:0] s;
        logic [ablm_pkg::SAMPLE_W-1:0] mag;
        logic [31:0]                   cnt;
        logic [63:0]                   pct;
        logic [31:0]                   fill;
        lvl = '0;
        if (run_words < 8'(ablm_pkg::MAX_BLOCK)) begin
            s   = w[31:8];
            mag = s[ablm_pkg::SAMPLE_W-1] ? (~s + 1'b1) : s;
            if (mag > run_peak) begin
                run_peak = mag;
            end
            run_sum   = run_sum + ablm_pkg::SUM_W'(mag);
            run_words = run_words + 8'd1;
        end
        if (!last) begin
            return 1'b0;
        end
        cnt  = (run_words == 0) ? 32'd1 : 32'(run_words);
        pct  = (64'(run_peak) * 64'd100) / 64'h7FFFFF;
        fill = 32'(pct) * 32'(ablm_pkg::BAR_LEN) / 32'd100;
        if (fill > 32'(ablm_pkg::BAR_LEN)) begin
            fill = 32'(ablm_pkg::BAR_LEN);
        end
        lvl.peak  = run_peak;
        lvl.mean  = ablm_pkg::SAMPLE_W'(32'(run_sum) / cnt);
        lvl.pct   = pct[ablm_pkg::PCT_W-1:0];
        lvl.fill  = fill[ablm_pkg::FILL_W-1:0];
        run_peak  = '0;
        run_sum   = '0;
        run_words = '0;
        return 1'b1;
    endfunction

    function automatic logic [ablm_pkg::WORD_W-1:0] pick_word();
        int v;
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h8000_00FF;
                endcase
            end
            2: begin
                v = int'($urandom_range(511)) - 256;
                return {24'(v), 8'($urandom)};
            end
            default: begin
                if ($urandom_range(1) == 0) begin
                    return {24'h7FFFFF - 24'($urandom_range(65535)), 8'($urandom)};
                end
                return {24'h800000 + 24'($urandom_range(65535)), 8'($urandom)};
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH result %0d %s: got %0d, want %0d", levels_checked, field, got, want);
        fail_cnt++;
    endtask

    task automatic send_beat(input logic [ablm_pkg::WORD_W-1:0] w, input logic last,
                             input logic typed, input t_level want);
        t_level lvl;
        i_valid       <= 1'b1;
        i_sample_word <= w;
        i_block_end   <= last;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        beats_sent++;
        if (meter_step(w, last, lvl)) begin
            levels_due.push_back(typed ? want : lvl);
            blocks_sent++;
        end
        if (!calm && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 40 : 3)) @(posedge i_clk);
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_ack) begin
                hold_ack = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (levels_due.size() == 0) begin
                flag_mismatch("unexpected result", 32'(o_peak_level), 32'd0);
            end else begin
                if (o_peak_level !== levels_due[0].peak) begin
                    flag_mismatch("peak_level", 32'(o_peak_level), 32'(levels_due[0].peak));
                end
                if (o_mean_level !== levels_due[0].mean) begin
                    flag_mismatch("mean_level", 32'(o_mean_level), 32'(levels_due[0].mean));
                end
                if (o_percent_full !== levels_due[0].pct) begin
                    flag_mismatch("percent_full", 32'(o_percent_full),
                                  32'(levels_due[0].pct));
                end
                if (o_bar_fill !== levels_due[0].fill) begin
                    flag_mismatch("bar_fill", 32'(o_bar_fill), 32'(levels_due[0].fill));
                end
                void'(levels_due.pop_front());
            end
            levels_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a beat", stall_cnt);
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        int     blen;
        logic   paused;
        t_level none;
        paused = 1'b0;
        none   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_DIR; r++) begin
            for (int k = 0; k < dir_tab[r].reps; k++) begin
                send_beat(dir_tab[r].word, dir_tab[r].last && (k == dir_tab[r].reps - 1),
                          dir_tab[r].typed, dir_tab[r].want);
            end
        end

        while (beats_sent < RAND_ITEMS) begin
            calm = (beats_sent >= 500 && beats_sent < 700);
            if (beats_sent >= 800) begin
                hold_req = 1'b1;
            end
            if (!paused && beats_sent >= 900) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                while (levels_due.size() != 0) begin
                    @(posedge i_clk);
                end
            end
            if ($urandom_range(24) == 0) begin
                blen = $urandom_range(125, 140);
                if (blen > ablm_pkg::MAX_BLOCK) begin
                    long_blocks++;
                end
            end else begin
                blen = $urandom_range(1, 12);
            end
            for (int k = 0; k < blen; k++) begin
                send_beat(pick_word(), k == blen - 1, 1'b0, none);
            end
        end
        i_valid <= 1'b0;

        while (levels_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (levels_due.size() != 0) begin
            flag_mismatch("results left over", 32'(levels_due.size()), 32'd0);
        end

        $display("Sent %0d beats in %0d blocks, %0d of them past the 128-word limit.",
                 beats_sent, blocks_sent, long_blocks);
        $display("Checked %0d results under random stalls, a long output hold and a drain.",
                 levels_checked);
        if (fail_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ablm_pkg.sv
rtl/core/ablm_div.sv
rtl/core/ablm_ctrl.sv
rtl/core/ablm_dp.sv
rtl/core/audio_block_level_meter.sv
tb/tb.sv
